// ----- src/vfa_pkg.sv -----
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared widths, opcodes and pipeline item type of the 3D vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vfa_pkg;

    localparam int WORD_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;

    // multiplier operand: word plus room for a-b
    localparam int MUL_W  = WORD_WIDTH + 2;
    localparam int RES_W  = 2 * MUL_W;
    localparam int SQ_W   = 2 * WORD_WIDTH + 2;
    localparam int ROOT_W = WORD_WIDTH + 1;
    localparam int REM_W  = ROOT_W + 3;
    localparam int QUO_W  = FRACTION_BITS + 1;
    localparam int NUM_W  = WORD_WIDTH + FRACTION_BITS;
    localparam int DREM_W = ROOT_W + 1;

    localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4,
        OP_MAG   = 3'd5,
        OP_NORM  = 3'd6,
        OP_DIST  = 3'd7
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [2:0]              neg;
        logic signed [RES_W-1:0] rx;
        logic signed [RES_W-1:0] ry;
        logic signed [RES_W-1:0] rz;
    } item_t;

endpackage

`default_nettype wire

// ----- src/vfa_prod.sv -----
// ----------------------------------------------------------------------------
// vfa_prod
// Three-stage front end: operand select, six products, combine into results.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_prod (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 adv,
    input  wire logic                                 in_valid,
    input  wire logic [2:0]                           in_op,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] in_a [3],
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] in_b [3],
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] in_s,
    output logic                                      out_valid,
    output vfa_pkg::item_t                            out_item,
    output logic [vfa_pkg::SQ_W-1:0]                  out_rad
);

    localparam int WW = vfa_pkg::WORD_WIDTH;
    localparam int MW = vfa_pkg::MUL_W;
    localparam int RW = vfa_pkg::RES_W;
    localparam int FB = vfa_pkg::FRACTION_BITS;

    vfa_pkg::op_t op;

    logic signed [MW-1:0] a_e [3];
    logic signed [MW-1:0] b_e [3];
    logic signed [MW-1:0] d_e [3];
    logic signed [MW-1:0] s_e;
    logic signed [MW-1:0] opa_next [6];
    logic signed [MW-1:0] opb_next [6];
    logic signed [MW-1:0] lin_next [3];
    logic [WW-1:0]        abs_next [3];
    logic [2:0]           neg_next;

    logic                 s1_valid_reg;
    vfa_pkg::op_t         s1_op_reg;
    logic signed [MW-1:0] opa_reg [6];
    logic signed [MW-1:0] opb_reg [6];
    logic signed [MW-1:0] s1_lin_reg [3];
    logic [WW-1:0]        s1_abs_reg [3];
    logic [2:0]           s1_neg_reg;

    logic                 s2_valid_reg;
    vfa_pkg::op_t         s2_op_reg;
    logic signed [RW-1:0] prod_reg [6];
    logic signed [MW-1:0] s2_lin_reg [3];
    logic [WW-1:0]        s2_abs_reg [3];
    logic [2:0]           s2_neg_reg;

    logic signed [RW-1:0] sum3;
    vfa_pkg::item_t       item_next;
    vfa_pkg::item_t       item_reg;
    logic                 s3_valid_reg;
    logic [vfa_pkg::SQ_W-1:0] rad_reg;

    assign op = vfa_pkg::op_t'(in_op);

    always_comb begin
        s_e = MW'(in_s);
        for (int i = 0; i < 3; i++) begin
            a_e[i]      = MW'(in_a[i]);
            b_e[i]      = MW'(in_b[i]);
            d_e[i]      = a_e[i] - b_e[i];
            lin_next[i] = (op == vfa_pkg::OP_SUB) ? d_e[i] : a_e[i] + b_e[i];
            neg_next[i] = in_a[i][WW-1];
            abs_next[i] = in_a[i][WW-1] ? (~in_a[i] + 1'b1) : in_a[i];
        end
        for (int i = 0; i < 6; i++) begin
            opa_next[i] = '0;
            opb_next[i] = '0;
        end
        unique case (op)
            vfa_pkg::OP_ADD, vfa_pkg::OP_SUB: begin
            end
            vfa_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    opa_next[i] = a_e[i];
                    opb_next[i] = s_e;
                end
            end
            vfa_pkg::OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    opa_next[i] = a_e[i];
                    opb_next[i] = b_e[i];
                end
            end
            vfa_pkg::OP_CROSS: begin
                opa_next[0] = a_e[1]; opb_next[0] = b_e[2];
                opa_next[1] = a_e[2]; opb_next[1] = b_e[1];
                opa_next[2] = a_e[2]; opb_next[2] = b_e[0];
                opa_next[3] = a_e[0]; opb_next[3] = b_e[2];
                opa_next[4] = a_e[0]; opb_next[4] = b_e[1];
                opa_next[5] = a_e[1]; opb_next[5] = b_e[0];
            end
            vfa_pkg::OP_MAG, vfa_pkg::OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    opa_next[i] = a_e[i];
                    opb_next[i] = a_e[i];
                end
            end
            vfa_pkg::OP_DIST: begin
                for (int i = 0; i < 3; i++) begin
                    opa_next[i] = d_e[i];
                    opb_next[i] = d_e[i];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg  <= op;
            s1_neg_reg <= neg_next;
            for (int i = 0; i < 6; i++) begin
                opa_reg[i] <= opa_next[i];
                opb_reg[i] <= opb_next[i];
            end
            for (int i = 0; i < 3; i++) begin
                s1_lin_reg[i] <= lin_next[i];
                s1_abs_reg[i] <= abs_next[i];
            end

            s2_op_reg  <= s1_op_reg;
            s2_neg_reg <= s1_neg_reg;
            for (int i = 0; i < 6; i++) begin
                prod_reg[i] <= opa_reg[i] * opb_reg[i];
            end
            for (int i = 0; i < 3; i++) begin
                s2_lin_reg[i] <= s1_lin_reg[i];
                s2_abs_reg[i] <= s1_abs_reg[i];
            end

            item_reg <= item_next;
            rad_reg  <= sum3[vfa_pkg::SQ_W-1:0];
        end
    end

    always_comb begin
        sum3          = prod_reg[0] + prod_reg[1] + prod_reg[2];
        item_next.op  = s2_op_reg;
        item_next.neg = s2_neg_reg;
        item_next.rx  = '0;
        item_next.ry  = '0;
        item_next.rz  = '0;
        unique case (s2_op_reg)
            vfa_pkg::OP_ADD, vfa_pkg::OP_SUB: begin
                item_next.rx = RW'(s2_lin_reg[0]);
                item_next.ry = RW'(s2_lin_reg[1]);
                item_next.rz = RW'(s2_lin_reg[2]);
            end
            vfa_pkg::OP_SCALE: begin
                item_next.rx = prod_reg[0] >>> FB;
                item_next.ry = prod_reg[1] >>> FB;
                item_next.rz = prod_reg[2] >>> FB;
            end
            vfa_pkg::OP_DOT: begin
                item_next.rx = sum3 >>> FB;
            end
            vfa_pkg::OP_CROSS: begin
                item_next.rx = (prod_reg[0] - prod_reg[1]) >>> FB;
                item_next.ry = (prod_reg[2] - prod_reg[3]) >>> FB;
                item_next.rz = (prod_reg[4] - prod_reg[5]) >>> FB;
            end
            vfa_pkg::OP_NORM: begin
                // magnitudes wait here for the divider
                item_next.rx = RW'(s2_abs_reg[0]);
                item_next.ry = RW'(s2_abs_reg[1]);
                item_next.rz = RW'(s2_abs_reg[2]);
            end
            vfa_pkg::OP_MAG, vfa_pkg::OP_DIST: begin
            end
        endcase
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = item_reg;
    assign out_rad   = rad_reg;

endmodule

`default_nettype wire

// ----- src/vfa_sqrt.sv -----
// ----------------------------------------------------------------------------
// vfa_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire vfa_pkg::item_t              in_item,
    input  wire logic [vfa_pkg::SQ_W-1:0]    in_rad,
    output logic                             out_valid,
    output vfa_pkg::item_t                   out_item,
    output logic [vfa_pkg::ROOT_W-1:0]       out_root
);

    localparam int N  = vfa_pkg::ROOT_W;
    localparam int SW = vfa_pkg::SQ_W;
    localparam int EW = vfa_pkg::REM_W;

    logic                 v_in    [N];
    vfa_pkg::item_t       item_in [N];
    logic [SW-1:0]        rad_in  [N];
    logic [EW-1:0]        rem_in  [N];
    logic [N-1:0]         root_in [N];

    logic                 v_reg    [N];
    vfa_pkg::item_t       item_reg [N];
    logic [SW-1:0]        rad_reg  [N];
    logic [EW-1:0]        rem_reg  [N];
    logic [N-1:0]         root_reg [N];

    assign v_in[0]    = in_valid;
    assign item_in[0] = in_item;
    assign rad_in[0]  = in_rad;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [EW-1:0] trial;
        logic [EW-1:0] trial_sub;
        logic          fits;

        if (k > 0) begin : g_link
            assign v_in[k]    = v_reg[k-1];
            assign item_in[k] = item_reg[k-1];
            assign rad_in[k]  = rad_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
        end

        // bring down the next two radicand bits, try (4*root + 1)
        assign trial     = {rem_in[k][EW-3:0], rad_in[k][SW-1 -: 2]};
        assign trial_sub = EW'({root_in[k], 2'b01});
        assign fits      = (trial >= trial_sub);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                item_reg[k] <= item_in[k];
                rad_reg[k]  <= rad_in[k] << 2;
                rem_reg[k]  <= fits ? trial - trial_sub : trial;
                root_reg[k] <= {root_in[k][N-2:0], fits};
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = item_reg[N-1];
    assign out_root  = root_reg[N-1];

endmodule

`default_nettype wire

// ----- src/vfa_div.sv -----
// ----------------------------------------------------------------------------
// vfa_div
// Three-lane pipelined restoring divider for normalize; also places roots.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire vfa_pkg::item_t              in_item,
    input  wire logic [vfa_pkg::ROOT_W-1:0]  in_root,
    output logic                             out_valid,
    output vfa_pkg::item_t                   out_item
);

    localparam int N  = vfa_pkg::QUO_W;
    localparam int WW = vfa_pkg::WORD_WIDTH;
    localparam int FB = vfa_pkg::FRACTION_BITS;
    localparam int RW = vfa_pkg::RES_W;
    localparam int DW = vfa_pkg::DREM_W;
    localparam int NW = vfa_pkg::NUM_W;
    localparam int TW = vfa_pkg::ROOT_W;

    logic                 v_in    [N];
    vfa_pkg::item_t       item_in [N];
    logic [TW-1:0]        root_in [N];
    logic [DW-1:0]        rem_in  [N][3];
    logic [N-1:0]         low_in  [N][3];
    logic [N-1:0]         quo_in  [N][3];

    logic                 v_reg    [N];
    vfa_pkg::item_t       item_reg [N];
    logic [TW-1:0]        root_reg [N];
    logic [DW-1:0]        rem_reg  [N][3];
    logic [N-1:0]         low_reg  [N][3];
    logic [N-1:0]         quo_reg  [N][3];

    logic [NW-1:0]        num [3];
    logic signed [RW-1:0] comp [3];
    logic signed [RW-1:0] qs   [3];
    vfa_pkg::item_t       res;
    vfa_pkg::item_t       last;
    logic [TW-1:0]        last_root;

    assign num[0] = {in_item.rx[WW-1:0], {FB{1'b0}}};
    assign num[1] = {in_item.ry[WW-1:0], {FB{1'b0}}};
    assign num[2] = {in_item.rz[WW-1:0], {FB{1'b0}}};

    assign v_in[0]    = in_valid;
    assign item_in[0] = in_item;
    assign root_in[0] = in_root;

    for (genvar l = 0; l < 3; l++) begin : g_lane_in
        // the top bits are already below the divisor since |a| <= root
        assign rem_in[0][l] = DW'(num[l][NW-1:N]);
        assign low_in[0][l] = num[l][N-1:0];
        assign quo_in[0][l] = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        if (k > 0) begin : g_link
            assign v_in[k]    = v_reg[k-1];
            assign item_in[k] = item_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane_link
                assign rem_in[k][l] = rem_reg[k-1][l];
                assign low_in[k][l] = low_reg[k-1][l];
                assign quo_in[k][l] = quo_reg[k-1][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                item_reg[k] <= item_in[k];
                root_reg[k] <= root_in[k];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DW-1:0] shifted;
            logic [DW-1:0] dvs;
            logic          fits;

            assign shifted = {rem_in[k][l][DW-2:0], low_in[k][l][N-1]};
            assign dvs     = DW'(root_in[k]);
            assign fits    = (shifted >= dvs);

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k][l] <= fits ? shifted - dvs : shifted;
                    low_reg[k][l] <= low_in[k][l] << 1;
                    quo_reg[k][l] <= {quo_in[k][l][N-2:0], fits};
                end
            end
        end
    end

    assign last      = item_reg[N-1];
    assign last_root = root_reg[N-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qs[l]   = RW'(quo_reg[N-1][l]);
            comp[l] = last.neg[l] ? -qs[l] : qs[l];
        end
        res = last;
        case (last.op)
            vfa_pkg::OP_MAG, vfa_pkg::OP_DIST: begin
                res.rx = RW'(last_root);
            end
            vfa_pkg::OP_NORM: begin
                if (last_root == '0) begin
                    res.rx = '0;
                    res.ry = '0;
                    res.rz = '0;
                end else begin
                    res.rx = comp[0];
                    res.ry = comp[1];
                    res.rz = comp[2];
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = res;

endmodule

`default_nettype wire

// ----- src/vec3_fixed_point_alu_unit.sv -----
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_unit
// Q16.16 3D vector unit: add, sub, scale, dot, cross, magnitude, normalize,
// distance, with saturation of every result component.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer is accepted every cycle while s_ready is high,
// and each result passes through 3 product stages, 33 square-root stages,
// 17 divider stages and the output register; every operation runs the same
// path so results leave in input order. s_ready follows the output register:
// the whole pipeline holds while a result waits to be taken.
`default_nettype none

module vec3_fixed_point_alu_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [2:0]                            s_opcode,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_a_x,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_a_y,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_a_z,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_b_x,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_b_y,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_b_z,
    input  wire logic signed [vfa_pkg::WORD_WIDTH-1:0] s_scale,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [vfa_pkg::WORD_WIDTH-1:0]      m_res_x,
    output logic signed [vfa_pkg::WORD_WIDTH-1:0]      m_res_y,
    output logic signed [vfa_pkg::WORD_WIDTH-1:0]      m_res_z,
    output logic                                       m_saturated
);

    localparam int WW = vfa_pkg::WORD_WIDTH;
    localparam int RW = vfa_pkg::RES_W;

    logic                          adv;
    logic signed [WW-1:0]          a_vec [3];
    logic signed [WW-1:0]          b_vec [3];

    logic                          prod_valid;
    vfa_pkg::item_t                prod_item;
    logic [vfa_pkg::SQ_W-1:0]      prod_rad;
    logic                          sqrt_valid;
    vfa_pkg::item_t                sqrt_item;
    logic [vfa_pkg::ROOT_W-1:0]    sqrt_root;
    logic                          div_valid;
    vfa_pkg::item_t                div_item;

    logic signed [RW-1:0]          comp [3];
    logic [WW-1:0]                 clamped [3];
    logic [2:0]                    over;

    logic                          m_valid_reg;
    logic [WW-1:0]                 res_x_reg;
    logic [WW-1:0]                 res_y_reg;
    logic [WW-1:0]                 res_z_reg;
    logic                          sat_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign a_vec[0] = s_a_x;
    assign a_vec[1] = s_a_y;
    assign a_vec[2] = s_a_z;
    assign b_vec[0] = s_b_x;
    assign b_vec[1] = s_b_y;
    assign b_vec[2] = s_b_z;

    vfa_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_op     (s_opcode),
        .in_a      (a_vec),
        .in_b      (b_vec),
        .in_s      (s_scale),
        .out_valid (prod_valid),
        .out_item  (prod_item),
        .out_rad   (prod_rad)
    );

    vfa_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (prod_valid),
        .in_item   (prod_item),
        .in_rad    (prod_rad),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item),
        .out_root  (sqrt_root)
    );

    vfa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sqrt_valid),
        .in_item   (sqrt_item),
        .in_root   (sqrt_root),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // out of range when the bits above the word's sign bit disagree with it
    always_comb begin
        comp[0] = div_item.rx;
        comp[1] = div_item.ry;
        comp[2] = div_item.rz;
        for (int i = 0; i < 3; i++) begin
            over[i] = (comp[i][RW-1:WW-1] != '0) && (comp[i][RW-1:WW-1] != '1);
            if (over[i]) begin
                clamped[i] = comp[i][RW-1] ? vfa_pkg::WORD_MIN : vfa_pkg::WORD_MAX;
            end else begin
                clamped[i] = comp[i][WW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && div_valid) begin
            res_x_reg <= clamped[0];
            res_y_reg <= clamped[1];
            res_z_reg <= clamped[2];
            sat_reg   <= |over;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_res_x     = res_x_reg;
    assign m_res_y     = res_y_reg;
    assign m_res_z     = res_z_reg;
    assign m_saturated = sat_reg;

endmodule

`default_nettype wire

// ----- src/vfa_checker.sv -----
// ----------------------------------------------------------------------------
// vfa_checker
// Port-level checks of the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [vfa_pkg::WORD_WIDTH-1:0] m_res_x,
    input wire logic [vfa_pkg::WORD_WIDTH-1:0] m_res_y,
    input wire logic [vfa_pkg::WORD_WIDTH-1:0] m_res_z,
    input wire logic                          m_saturated
);

    // a held result must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_x) && $stable(m_res_y)
            && $stable(m_res_z) && $stable(m_saturated))
        else $error("result changed while stalled");

    // empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with output empty");

    // a taken result frees the pipeline in the same cycle
    a_ready_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input blocked while result taken");

    // saturation shows as at least one extreme word
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_res_x == vfa_pkg::WORD_MAX || m_res_x == vfa_pkg::WORD_MIN ||
            m_res_y == vfa_pkg::WORD_MAX || m_res_y == vfa_pkg::WORD_MIN ||
            m_res_z == vfa_pkg::WORD_MAX || m_res_z == vfa_pkg::WORD_MIN)
        else $error("saturated flag without clamped component");

endmodule

bind vec3_fixed_point_alu_unit vfa_checker u_vfa_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_res_x     (m_res_x),
    .m_res_y     (m_res_y),
    .m_res_z     (m_res_z),
    .m_saturated (m_saturated)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the 3D vector unit with directed corner operands and random vectors
// on both handshake channels, predicts each result and compares it in order.
// ----------------------------------------------------------------------------

typedef logic signed [127:0] wide_t;

typedef struct {
    vfa_pkg::op_t                          op;
    logic signed [vfa_pkg::WORD_WIDTH-1:0] ax, ay, az, bx, by, bz, s;
} operands_t;

typedef struct {
    logic [vfa_pkg::WORD_WIDTH-1:0] x, y, z;
    logic                           sat;
} vec_result_t;

class vector_scoreboard;
    vec_result_t expected_q[$];
    int          mismatches = 0;

    function automatic wide_t floor_root(wide_t n);
        wide_t rem, root, b;
        rem  = n;
        root = 0;
        b    = wide_t'(1) <<< 126;
        for (int i = 0; i < 64; i++) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    function automatic logic [vfa_pkg::WORD_WIDTH-1:0] clamp(wide_t v, ref logic sat);
        wide_t hi, lo;
        hi = $signed(vfa_pkg::WORD_MAX);
        lo = $signed(vfa_pkg::WORD_MIN);
        if (v > hi) begin
            sat = 1'b1;
            return vfa_pkg::WORD_MAX;
        end
        if (v < lo) begin
            sat = 1'b1;
            return vfa_pkg::WORD_MIN;
        end
        return v[vfa_pkg::WORD_WIDTH-1:0];
    endfunction

    function automatic vec_result_t vector_result(operands_t o);
        wide_t a[3], b[3], r[3], m, q;
        vec_result_t res;
        logic sat;
        a[0] = o.ax; a[1] = o.ay; a[2] = o.az;
        b[0] = o.bx; b[1] = o.by; b[2] = o.bz;
        r[0] = 0; r[1] = 0; r[2] = 0;
        sat  = 1'b0;
        case (o.op)
            vfa_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            vfa_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            vfa_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++)
                    r[i] = (a[i] * wide_t'(o.s)) >>> vfa_pkg::FRACTION_BITS;
            end
            vfa_pkg::OP_DOT:
                r[0] = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> vfa_pkg::FRACTION_BITS;
            vfa_pkg::OP_CROSS: begin
                r[0] = (a[1]*b[2] - a[2]*b[1]) >>> vfa_pkg::FRACTION_BITS;
                r[1] = (a[2]*b[0] - a[0]*b[2]) >>> vfa_pkg::FRACTION_BITS;
                r[2] = (a[0]*b[1] - a[1]*b[0]) >>> vfa_pkg::FRACTION_BITS;
            end
            vfa_pkg::OP_MAG: r[0] = floor_root(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
            vfa_pkg::OP_NORM: begin
                m = floor_root(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
                if (m != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        q    = ((a[i] < 0 ? -a[i] : a[i]) <<< vfa_pkg::FRACTION_BITS) / m;
                        r[i] = (a[i] < 0) ? -q : q;
                    end
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) b[i] = a[i] - b[i];
                r[0] = floor_root(b[0]*b[0] + b[1]*b[1] + b[2]*b[2]);
            end
        endcase
        res.x   = clamp(r[0], sat);
        res.y   = clamp(r[1], sat);
        res.z   = clamp(r[2], sat);
        res.sat = sat;
        return res;
    endfunction

    function void note_operands(operands_t o);
        expected_q.push_back(vector_result(o));
    endfunction

    function void check_result(vec_result_t got);
        vec_result_t exp_r;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result transfer with nothing expected");
            return;
        end
        exp_r = expected_q.pop_front();
        if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z
                || got.sat !== exp_r.sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %h %h %h sat %b, got %h %h %h sat %b",
                         exp_r.x, exp_r.y, exp_r.z, exp_r.sat,
                         got.x, got.y, got.z, got.sat);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;
    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_saturated;
    logic [2:0] s_opcode;
    logic signed [vfa_pkg::WORD_WIDTH-1:0] s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z;
    logic signed [vfa_pkg::WORD_WIDTH-1:0] s_scale;
    logic signed [vfa_pkg::WORD_WIDTH-1:0] m_res_x, m_res_y, m_res_z;

    vector_scoreboard sb = new();
    bit  hold_request = 0;
    bit  burst = 0;
    bit  stimulus_done = 0;
    int  quiet_cycles = 0;

    always #2 aclk = ~aclk;

    vec3_fixed_point_alu_unit dut (.*);

    function automatic logic signed [vfa_pkg::WORD_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 4) == 0 ? vfa_pkg::WORD_MAX :
                      $urandom_range(0, 3) == 0 ? vfa_pkg::WORD_MIN :
                      $urandom_range(0, 1) ? 32'sd0 : 32'sh0001_0000;
            1, 2: return $signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(operands_t o);
        s_valid  <= 1'b1;
        s_opcode <= o.op;
        s_a_x <= o.ax; s_a_y <= o.ay; s_a_z <= o.az;
        s_b_x <= o.bx; s_b_y <= o.by; s_b_z <= o.bz;
        s_scale <= o.s;
        do @(posedge aclk); while (!s_ready);
        sb.note_operands(o);
    endtask

    task automatic send_gap();
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic operands_t mk(vfa_pkg::op_t op,
                                     logic signed [vfa_pkg::WORD_WIDTH-1:0] a,
                                     logic signed [vfa_pkg::WORD_WIDTH-1:0] b,
                                     logic signed [vfa_pkg::WORD_WIDTH-1:0] s);
        operands_t o;
        o.op = op; o.ax = a; o.ay = a; o.az = a; o.bx = b; o.by = b; o.bz = b; o.s = s;
        return o;
    endfunction

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side
    initial begin
        int stall;
        vec_result_t got;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 11);
            if (hold_request) begin
                hold_request = 0;
                stall = 400;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.x = m_res_x; got.y = m_res_y; got.z = m_res_z; got.sat = m_saturated;
            sb.check_result(got);
        end
    end

    initial begin
        operands_t o;
        logic signed [vfa_pkg::WORD_WIDTH-1:0] corner[4];
        corner = '{vfa_pkg::WORD_MAX, vfa_pkg::WORD_MIN, 32'sd0, -32'sd1};
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_opcode <= vfa_pkg::OP_ADD;
        s_a_x <= 0; s_a_y <= 0; s_a_z <= 0; s_b_x <= 0; s_b_y <= 0; s_b_z <= 0;
        s_scale <= 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every op on max/min operands, zero vector, mixed signs
        for (int k = 0; k < 8; k++) begin
            send_gap();
            send(mk(vfa_pkg::op_t'(k), vfa_pkg::WORD_MAX, vfa_pkg::WORD_MIN,
                    vfa_pkg::WORD_MIN));
            send_gap();
            send(mk(vfa_pkg::op_t'(k), vfa_pkg::WORD_MIN, vfa_pkg::WORD_MAX,
                    vfa_pkg::WORD_MAX));
        end
        send_gap(); send(mk(vfa_pkg::OP_NORM, 0, vfa_pkg::WORD_MAX, vfa_pkg::WORD_MAX));
        send_gap(); send(mk(vfa_pkg::OP_MAG, 0, 0, 0));
        send_gap(); send(mk(vfa_pkg::OP_DIST, -32'sd5, -32'sd5, 0));
        o = mk(vfa_pkg::OP_CROSS, 32'sh0001_0000, 0, 0);
        o.ay = -32'sh0003_8000; o.bz = 32'sh0002_0000; o.bx = vfa_pkg::WORD_MIN;
        send_gap(); send(o);
        o.op = vfa_pkg::OP_NORM; send_gap(); send(o);

        for (int n = 0; n < 1250; n++) begin
            burst = (n >= 300 && n < 380);
            if (n == 600) hold_request = 1;
            if (n == 900) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
            end
            o.op = vfa_pkg::op_t'($urandom_range(0, 7));
            o.ax = rand_word(); o.ay = rand_word(); o.az = rand_word();
            o.bx = rand_word(); o.by = rand_word(); o.bz = rand_word();
            o.s  = rand_word();
            if ($urandom_range(0, 9) == 0) o.ax = corner[$urandom_range(0, 3)];
            send_gap();
            send(o);
        end
        s_valid <= 1'b0;
        burst = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
